### hw/rtl/aamc_pkg.sv
// ----------------------------------------------------------------------------
// aamc_pkg
// types and constants shared by the aggregation mode controller
// ----------------------------------------------------------------------------
package aamc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_BYTE_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BUDGET           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DYNAMIC_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DYNAMIC_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREAGG_RATE           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH_RATE      = 3'd5;

  // register reset values
  localparam logic [39:0] RST_INIT_BYTE_THRESHOLD   = 40'd2097152;
  localparam logic [31:0] RST_BASE_BUDGET           = 32'd65536;
  localparam logic [31:0] RST_INITIAL_DYNAMIC_LIMIT = 32'd65536;
  localparam logic [31:0] RST_MAX_DYNAMIC_LIMIT     = 32'd1048576;
  localparam logic [16:0] RST_PREAGG_RATE           = 17'd58982;
  localparam logic [16:0] RST_PASSTHROUGH_RATE      = 17'd13107;

  // q1.16 one
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // mode codes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_ADJUST = 3'd1;
  localparam logic [2:0] MODE_PREAGG = 3'd2;
  localparam logic [2:0] MODE_PASS   = 3'd3;
  localparam logic [2:0] MODE_SELECT = 3'd4;

  // action codes
  localparam logic [1:0] ACT_AGG       = 2'd0;
  localparam logic [1:0] ACT_AGG_COUNT = 2'd1;
  localparam logic [1:0] ACT_LOOKUP    = 2'd2;
  localparam logic [1:0] ACT_PASS      = 2'd3;

  typedef struct packed {
    logic [39:0] init_byte_threshold;
    logic [31:0] base_budget;
    logic [31:0] max_dynamic_limit;
    logic [16:0] preagg_rate;
    logic [16:0] passthrough_rate;
  } cfg_t;

  typedef struct packed {
    logic [15:0] row_count;
    logic [15:0] hit_count;
    logic [39:0] table_bytes;
    logic        force_pass;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] next_mode;
    logic       mode_changed;
  } out_item_t;

endpackage

### hw/rtl/aamc_cfg.sv
// ----------------------------------------------------------------------------
// aamc_cfg
// configuration register file of the aggregation mode controller
// ----------------------------------------------------------------------------
module aamc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [aamc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [aamc_pkg::CFG_DATA_W-1:0] wr_data,
  output aamc_pkg::cfg_t                  cfg
);
  import aamc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_byte_threshold <= RST_INIT_BYTE_THRESHOLD;
      cfg_r.base_budget         <= RST_BASE_BUDGET;
      cfg_r.max_dynamic_limit   <= RST_MAX_DYNAMIC_LIMIT;
      cfg_r.preagg_rate         <= RST_PREAGG_RATE;
      cfg_r.passthrough_rate    <= RST_PASSTHROUGH_RATE;
    end else if (wr_en) begin
      case (wr_index)
        REG_INIT_BYTE_THRESHOLD: cfg_r.init_byte_threshold <= wr_data[39:0];
        REG_BASE_BUDGET:         cfg_r.base_budget         <= wr_data[31:0];
        REG_MAX_DYNAMIC_LIMIT:   cfg_r.max_dynamic_limit   <= wr_data[31:0];
        REG_PREAGG_RATE:         cfg_r.preagg_rate         <= wr_data[16:0];
        REG_PASSTHROUGH_RATE:    cfg_r.passthrough_rate    <= wr_data[16:0];
        default: ; // budget start lives in the core, unknown indexes ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/aamc_core.sv
// ----------------------------------------------------------------------------
// aamc_core
// mode state, saturating counters and the per-block decision
// ----------------------------------------------------------------------------
module aamc_core #(
  parameter int COUNT_BITS = 32,
  parameter int ROW_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aamc_pkg::cfg_t       cfg,
  input  logic                 budget_load,
  input  logic [31:0]          budget_value,
  input  logic                 step,
  input  aamc_pkg::in_item_t   item,
  output aamc_pkg::out_item_t  result
);
  import aamc_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int PW = COUNT_BITS + 17;
  localparam logic [15:0] ROW_MASK = 16'((64'd1 << ROW_BITS) - 64'd1);

  logic [2:0]    mode_r, mode_nxt;
  logic [CB-1:0] sample_rows_r, sample_rows_nxt;
  logic [CB-1:0] sample_hits_r, sample_hits_nxt;
  logic [CB-1:0] mode_rows_r, mode_rows_nxt;
  logic [31:0]   backoff_r, backoff_nxt;

  logic [15:0]   rows, hits_raw, hits;
  logic [2:0]    eff_mode;
  logic [CB:0]   s_rows_sum, s_hits_sum, m_rows_sum;
  logic [CB-1:0] s_rows_sat, s_hits_sat, m_rows_sat;
  logic [PW-1:0] lhs, pre_prod, pass_prod;
  logic          ge_pre, le_pass, sample_done, budget_done, dyn;
  logic [31:0]   limit;
  logic [32:0]   backoff_dbl;
  logic [1:0]    action;

  assign rows     = item.row_count & ROW_MASK;
  assign hits_raw = item.hit_count & ROW_MASK;
  assign hits     = (hits_raw > rows) ? rows : hits_raw;
  assign eff_mode = item.force_pass ? MODE_PASS : mode_r;

  // saturating counters
  assign s_rows_sum = {1'b0, sample_rows_r} + (CB+1)'(rows);
  assign s_hits_sum = {1'b0, sample_hits_r} + (CB+1)'(hits);
  assign m_rows_sum = {1'b0, mode_rows_r} + (CB+1)'(rows);
  assign s_rows_sat = s_rows_sum[CB] ? {CB{1'b1}} : s_rows_sum[CB-1:0];
  assign s_hits_sat = s_hits_sum[CB] ? {CB{1'b1}} : s_hits_sum[CB-1:0];
  assign m_rows_sat = m_rows_sum[CB] ? {CB{1'b1}} : m_rows_sum[CB-1:0];

  // hit rate against thresholds by cross-multiplying
  assign lhs       = PW'({s_hits_sat, 16'h0000});
  assign pre_prod  = PW'(cfg.preagg_rate) * PW'(s_rows_sat);
  assign pass_prod = PW'(cfg.passthrough_rate) * PW'(s_rows_sat);

  always_comb begin
    if (s_rows_sat == '0) begin
      ge_pre  = (cfg.preagg_rate == '0);
      le_pass = 1'b1;
    end else begin
      ge_pre  = (cfg.preagg_rate > ONE_Q16) ? 1'b0 : (lhs >= pre_prod);
      le_pass = (cfg.passthrough_rate >= ONE_Q16) ? 1'b1 : (lhs <= pass_prod);
    end
  end

  assign sample_done = LW'(s_rows_sat) >= LW'(cfg.base_budget);

  assign dyn         = (eff_mode == MODE_PASS) || (eff_mode == MODE_SELECT);
  assign limit       = dyn ? backoff_r : cfg.base_budget;
  assign budget_done = LW'(m_rows_sat) >= LW'(limit);
  assign backoff_dbl = {backoff_r, 1'b0};

  always_comb begin
    mode_nxt        = eff_mode;
    sample_rows_nxt = sample_rows_r;
    sample_hits_nxt = sample_hits_r;
    mode_rows_nxt   = mode_rows_r;
    backoff_nxt     = backoff_r;
    action          = ACT_AGG;
    case (eff_mode)
      MODE_ADJUST: begin
        action = ACT_AGG_COUNT;
        if (sample_done) begin
          if (ge_pre) begin
            mode_nxt = MODE_PREAGG;
          end else if (le_pass) begin
            mode_nxt = MODE_PASS;
          end else begin
            mode_nxt = MODE_SELECT;
          end
          sample_rows_nxt = '0;
          sample_hits_nxt = '0;
        end else begin
          sample_rows_nxt = s_rows_sat;
          sample_hits_nxt = s_hits_sat;
        end
      end
      MODE_PREAGG, MODE_PASS, MODE_SELECT: begin
        case (eff_mode)
          MODE_PREAGG: action = ACT_AGG;
          MODE_PASS:   action = ACT_PASS;
          default:     action = ACT_LOOKUP;
        endcase
        if (budget_done) begin
          if (dyn) begin
            backoff_nxt = (backoff_dbl < {1'b0, cfg.max_dynamic_limit}) ?
                          backoff_dbl[31:0] : cfg.max_dynamic_limit;
          end
          mode_nxt      = MODE_ADJUST;
          mode_rows_nxt = '0;
        end else begin
          mode_rows_nxt = m_rows_sat;
        end
      end
      default: begin
        // init and unused codes
        action = ACT_AGG;
        if (item.table_bytes > cfg.init_byte_threshold) begin
          mode_nxt = MODE_ADJUST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_INIT;
      sample_rows_r <= '0;
      sample_hits_r <= '0;
      mode_rows_r   <= '0;
      backoff_r     <= RST_INITIAL_DYNAMIC_LIMIT;
    end else begin
      if (step) begin
        mode_r        <= mode_nxt;
        sample_rows_r <= sample_rows_nxt;
        sample_hits_r <= sample_hits_nxt;
        mode_rows_r   <= mode_rows_nxt;
        backoff_r     <= backoff_nxt;
      end
      if (budget_load) begin
        backoff_r <= budget_value;
      end
    end
  end

  assign result.action       = action;
  assign result.next_mode    = mode_nxt;
  assign result.mode_changed = (mode_nxt != mode_r);

endmodule

### hw/rtl/adaptive_aggregation_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// adaptive_aggregation_mode_controller_unit
// picks how each data block is aggregated and tracks the controller mode
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_item   (aamc_pkg::in_item_t)
//   out_     output     out_valid / out_stall out_item  (aamc_pkg::out_item_t)
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each item passes
// through the input register and then sits in the result register
// the mode and counters update as an item moves from the input register
// into the result register, so the next item sees them immediately
// synchronous active-low reset clears state; config returns to defaults
// a stalled result register holds the input register, which then stalls in_
//
module adaptive_aggregation_mode_controller_unit #(
  parameter int COUNT_BITS = 32,
  parameter int ROW_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // block events
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aamc_pkg::in_item_t              in_item,
  // decisions
  output logic                            out_valid,
  input  logic                            out_stall,
  output aamc_pkg::out_item_t             out_item,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aamc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aamc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aamc_pkg::*;

  cfg_t      cfg;
  logic      cfg_wr;

  // input register
  logic      in_vld_r;
  in_item_t  in_item_r;

  // result register
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;

  logic      in_fire;
  logic      advance;
  logic      step;

  // register writes always accepted
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  aamc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register can take a new item when empty or being drained
  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  // input register frees up whenever its item moves on
  assign in_stall = in_vld_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  aamc_core #(
    .COUNT_BITS (COUNT_BITS),
    .ROW_BITS   (ROW_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .budget_load  (cfg_wr && (cfg_index == REG_INITIAL_DYNAMIC_LIMIT)),
    .budget_value (cfg_data[31:0]),
    .step         (step),
    .item         (in_item_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_item;
    end
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
